### rtl/slfr_pkg.sv
// Shared types and constants for the sync/length frame receiver.
`timescale 1ns / 1ps

package slfr_pkg;

    localparam int SLOT_COUNT_DEF = 3;
    localparam int SLOT_BYTES_DEF = 64;
    localparam logic [7:0] SYNC_RESET = 8'h7E;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_LEN  = 3'd1,
        EV_PAY  = 3'd2,
        EV_GOOD = 3'd3,
        EV_BAD  = 3'd4,
        EV_DROP = 3'd5
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_out;
        logic [1:0]  slot;
        logic [5:0]  offset;
    } t_result;

endpackage

### rtl/sync_length_frame_receiver_top.sv
// Top level of the sync/length frame receiver with Fletcher-style checking.
`timescale 1ns / 1ps

// Usage:
// Received serial bytes enter one word at a time on the input channel
// (i_in_valid / o_in_ready / i_rx_byte). Every input word produces exactly
// one result word on the output channel (o_out_valid / i_out_ready and the
// o_event_res, o_data_out, o_slot, o_offset fields): a write of the length
// or a payload byte into slot/offset of an external ring buffer, a frame
// verdict, an oversize drop, or an empty event.
// An accepted word is held in the input register while the deframer logic
// computes its result, which loads the result register when it is free.
// Throughput is one word per cycle while no stall holds the flow; the input
// register and the result register each take a new word in the same cycle
// that they hand one on, so nothing bubbles when both sides keep up.
// When the receiver stalls, the result register holds its word, the input
// register fills, and o_in_ready drops; no word is lost and the frame state
// only advances as words move into the result register.
// Reset (i_rst_n low at a clock edge) empties both registers, returns the
// deframer to sync hunting with the ring at the last slot so the first frame
// lands in slot 0, and restores the sync byte to 0x7E. The user changes the
// sync byte via i_cfg_we / i_cfg_data only while the block is idle (unenforced).

module sync_length_frame_receiver_top #(
    parameter int SLOT_COUNT = slfr_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = slfr_pkg::SLOT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_out,
    output logic [1:0] o_slot,
    output logic [5:0] o_offset
);
    import slfr_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_free;
    logic       advance;
    t_result    step_result;
    t_result    out_result;

    // A held word moves on whenever the result register can take it.
    assign advance = held_valid && out_free;

    slfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_byte    (i_rx_byte),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_byte    (held_byte)
    );

    slfr_deframer #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_deframer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_byte     (held_byte),
        .o_result   (step_result)
    );

    slfr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (held_valid),
        .i_result (step_result),
        .o_ready  (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_event_res = out_result.event_res;
    assign o_data_out  = out_result.data_out;
    assign o_slot      = out_result.slot;
    assign o_offset    = out_result.offset;

endmodule

### rtl/slfr_in_stage.sv
// Input register stage that holds one received word for the deframer.
`timescale 1ns / 1ps

module slfr_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

### rtl/slfr_deframer.sv
// Frame state machine, checksums, slot ring and per-word result logic.
`timescale 1ns / 1ps

module slfr_deframer #(
    parameter int SLOT_COUNT = slfr_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = slfr_pkg::SLOT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    output slfr_pkg::t_result o_result
);
    import slfr_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int OFF_W  = $clog2(SLOT_BYTES);

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_PAY   = 6'b000100,
        PH_CK1   = 6'b001000,
        PH_CK2   = 6'b010000,
        PH_FLUSH = 6'b100000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [OFF_W-1:0]  r_offset, n_offset;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_sum_lo, n_sum_lo;
    logic [7:0]        r_sum_hi, n_sum_hi;
    logic [7:0]        r_sync;

    logic [31:0]       slot_ext;
    logic [31:0]       off_ext;
    t_result           res;

    assign slot_ext = 32'(n_slot);
    assign off_ext  = 32'(r_offset);

    always_comb begin
        n_phase  = r_phase;
        n_slot   = r_slot;
        n_offset = r_offset;
        n_len    = r_len;
        n_sum_lo = r_sum_lo;
        n_sum_hi = r_sum_hi;
        res      = '0;

        unique case (r_phase)
            PH_LEN: begin
                n_len = i_byte;
                res.data_out = i_byte;
                if (9'(i_byte) >= 9'(SLOT_BYTES)) begin
                    n_phase = PH_FLUSH;
                    res.event_res = EV_DROP;
                end else begin
                    if (r_slot == SLOT_W'(SLOT_COUNT - 1)) begin
                        n_slot = '0;
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                    n_sum_lo = '0;
                    n_sum_hi = '0;
                    n_offset = OFF_W'(1);
                    n_phase  = (i_byte == 8'd0) ? PH_CK1 : PH_PAY;
                    res.event_res = EV_LEN;
                end
            end
            PH_PAY: begin
                n_sum_lo = r_sum_lo + i_byte;
                n_sum_hi = r_sum_hi + n_sum_lo;
                n_offset = r_offset + OFF_W'(1);
                if (9'(r_offset) >= 9'(r_len)) begin
                    n_phase = PH_CK1;
                end
                res.event_res = EV_PAY;
                res.data_out  = i_byte;
                res.offset    = off_ext[5:0];
            end
            PH_CK1: begin
                if (i_byte != r_sum_hi) begin
                    res.event_res = EV_BAD;
                    res.data_out  = r_len;
                    n_len   = 8'd1;
                    n_phase = PH_FLUSH;
                end else begin
                    n_phase = PH_CK2;
                end
            end
            PH_CK2: begin
                res.event_res = (i_byte == r_sum_lo) ? EV_GOOD : EV_BAD;
                res.data_out  = r_len;
                n_phase = PH_HUNT;
            end
            PH_FLUSH: begin
                if (r_len <= 8'd1) begin
                    n_len   = 8'd0;
                    n_phase = PH_HUNT;
                end else begin
                    n_len = r_len - 8'd1;
                end
            end
            default: begin
                n_phase = (i_byte == r_sync) ? PH_LEN : PH_HUNT;
            end
        endcase

        // The slot reported is the one in use after this word is taken.
        res.slot = slot_ext[1:0];
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_slot   <= SLOT_W'(SLOT_COUNT - 1);
            r_offset <= '0;
            r_len    <= '0;
            r_sum_lo <= '0;
            r_sum_hi <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_offset <= n_offset;
            r_len    <= n_len;
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
        end
    end

    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < SLOT_COUNT)
        else $error("slot index outside the ring");

    a_pay_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_offset != '0) && (9'(r_offset) <= 9'(r_len)))
        else $error("payload offset outside the frame");

    a_pay_len_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (9'(r_len) < 9'(SLOT_BYTES)))
        else $error("payload phase with oversize length");

    a_ck1_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_CK1 && i_byte == r_sum_hi) |=> (r_phase == PH_CK2))
        else $error("matching first check word did not reach second check");

endmodule

### rtl/slfr_out_stage.sv
// Result register stage that holds one result word until it is taken.
`timescale 1ns / 1ps

module slfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  slfr_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output slfr_pkg::t_result o_result
);
    import slfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### dv/sync_length_frame_receiver_top_tb.sv
// Self-checking testbench for the sync/length frame receiver top level.
`timescale 1ns / 1ps

module sync_length_frame_receiver_top_tb;

    import slfr_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;     // comfortably past the input and result registers
    localparam int STALL_LIMIT   = 4000;  // cycles without any word moving
    localparam int PHASE_WORDS   = 230;   // random words per phase, eight phases
    localparam int RANDOM_SYNC   = -1;

    // Deframer phases, kept in the testbench's own copy of the block's state.
    typedef enum logic [2:0] {
        P_HUNT  = 3'd0,
        P_LEN   = 3'd1,
        P_PAY   = 3'd2,
        P_CK1   = 3'd3,
        P_CK2   = 3'd4,
        P_FLUSH = 3'd5
    } t_phase;

    // Tracks the deframer: every accepted byte is turned into the result word
    // the block must produce, and result words are checked against them in order.
    class deframe_tracker;
        t_phase     ph;
        int         slot_idx;
        logic [6:0] wr_off;
        logic [7:0] frame_len;
        logic [7:0] sum_lo;
        logic [7:0] sum_hi;
        logic [7:0] sync_val;
        t_result    expected_words[$];
        int         errors;

        function new();
            ph        = P_HUNT;
            slot_idx  = SLOT_COUNT_DEF - 1;
            wr_off    = '0;
            frame_len = '0;
            sum_lo    = '0;
            sum_hi    = '0;
            sync_val  = SYNC_RESET;
            errors    = 0;
        endfunction

        function void set_sync(logic [7:0] v);
            sync_val = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_byte(logic [7:0] b);
            t_result    r;
            logic [6:0] off;
            r.event_res = EV_NONE;
            r.data_out  = '0;
            r.offset    = '0;
            case (ph)
                P_LEN: begin
                    frame_len = b;
                    if (int'(b) >= SLOT_BYTES_DEF) begin
                        // Too long for a slot: report it, then swallow the body.
                        ph          = P_FLUSH;
                        r.event_res = EV_DROP;
                        r.data_out  = b;
                    end else begin
                        slot_idx    = (slot_idx >= SLOT_COUNT_DEF - 1) ? 0 : slot_idx + 1;
                        sum_lo      = '0;
                        sum_hi      = '0;
                        wr_off      = 7'd1;
                        ph          = (b == 8'd0) ? P_CK1 : P_PAY;
                        r.event_res = EV_LEN;
                        r.data_out  = b;
                    end
                end
                P_PAY: begin
                    off    = wr_off;
                    sum_lo = sum_lo + b;
                    sum_hi = sum_hi + sum_lo;
                    wr_off = wr_off + 7'd1;
                    if ({1'b0, off} >= {1'b0, frame_len}) begin
                        ph = P_CK1;
                    end
                    r.event_res = EV_PAY;
                    r.data_out  = b;
                    r.offset    = off[5:0];
                end
                P_CK1: begin
                    if (b != sum_hi) begin
                        // A bad first check costs one extra flushed byte.
                        r.event_res = EV_BAD;
                        r.data_out  = frame_len;
                        frame_len   = 8'd1;
                        ph          = P_FLUSH;
                    end else begin
                        ph = P_CK2;
                    end
                end
                P_CK2: begin
                    r.event_res = (b == sum_lo) ? EV_GOOD : EV_BAD;
                    r.data_out  = frame_len;
                    ph          = P_HUNT;
                end
                P_FLUSH: begin
                    if (frame_len <= 8'd1) begin
                        frame_len = '0;
                        ph        = P_HUNT;
                    end else begin
                        frame_len = frame_len - 8'd1;
                    end
                end
                default: begin
                    ph = (b == sync_val) ? P_LEN : P_HUNT;
                end
            endcase
            r.slot = 2'(slot_idx);
            expected_words.push_back(r);
        endfunction

        function void check_word(logic [2:0] ev, logic [7:0] data, logic [1:0] sl,
                                 logic [5:0] off);
            t_result e;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("MISMATCH: unexpected word ev=%0d data=%02h slot=%0d off=%0d",
                             ev, data, sl, off);
                end
                return;
            end
            e = expected_words.pop_front();
            if (e.event_res != ev || e.data_out != data || e.slot != sl || e.offset != off) begin
                errors++;
                if (errors <= 10) begin
                    $display("MISMATCH: expected ev=%0d data=%02h slot=%0d off=%0d, got ev=%0d data=%02h slot=%0d off=%0d",
                             e.event_res, e.data_out, e.slot, e.offset, ev, data, sl, off);
                end
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_event_res;
    logic [7:0] o_data_out;
    logic [1:0] o_slot;
    logic [5:0] o_offset;

    deframe_tracker tracker = new();

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         words_sent     = 0;
    int         quiet_cycles   = 0;
    logic [7:0] cur_sync       = SYNC_RESET;

    sync_length_frame_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_event_res (o_event_res),
        .o_data_out  (o_data_out),
        .o_slot      (o_slot),
        .o_offset    (o_offset)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // The receiver decides once per cycle, at the falling edge, whether to take a word.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // All sampling happens at the rising edge. The input word is noted before
    // the result is checked; results are registered, so the order is harmless.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_byte(i_rx_byte);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_word(o_event_res, o_data_out, o_slot, o_offset);
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one word and returns at the falling edge after it is accepted.
    // Valid is only lowered when the sender decides to idle, so a back-to-back
    // word never sees valid drop and rise within one time step.
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == cur_sync) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    // Lets every expected word drain, waits out the pipeline, then changes
    // the sync byte. The sender is held off for the whole time.
    task automatic write_sync(input logic [7:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.set_sync(v);
        cur_sync = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random payload, a few with broken checks,
    // some oversize lengths, and occasional runs of raw noise that may start
    // frames at odd places.
    task automatic send_frame();
        int         kind;
        int         len;
        int         n;
        int         verdict;
        logic [7:0] b;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] flip;
        if ($urandom_range(99) < 20) begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(non_sync_byte());
        end
        kind = $urandom_range(99);
        if (kind < 5) begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(8'($urandom));
            return;
        end
        send_word(cur_sync);
        if (kind < 13) begin
            // Oversize: usually just past the slot size, rarely any length up to the largest.
            len = ($urandom_range(9) == 0) ? $urandom_range(SLOT_BYTES_DEF, 255)
                                           : $urandom_range(SLOT_BYTES_DEF, SLOT_BYTES_DEF + 6);
            send_word(8'(len));
            repeat (len) send_word(8'($urandom));
            return;
        end
        n = $urandom_range(99);
        if (n < 15) begin
            len = 0;
        end else if (n < 75) begin
            len = $urandom_range(1, 8);
        end else if (n < 95) begin
            len = $urandom_range(9, 40);
        end else begin
            len = $urandom_range(41, SLOT_BYTES_DEF - 1);
        end
        send_word(8'(len));
        lo = '0;
        hi = '0;
        repeat (len) begin
            b  = 8'($urandom);
            lo = lo + b;
            hi = hi + lo;
            send_word(b);
        end
        flip    = 8'($urandom_range(1, 255));
        verdict = $urandom_range(99);
        if (verdict < 80) begin
            send_word(hi);
            send_word(lo);
        end else if (verdict < 90) begin
            // Bad first check, followed by the byte the block flushes.
            send_word(hi ^ flip);
            send_word(8'($urandom));
        end else begin
            send_word(hi);
            send_word(lo ^ flip);
        end
    endtask

    // Directed words under the reset sync byte 0x7E:
    //   two non-sync bytes at the extremes while hunting;
    //   a zero-length frame with both checks zero;
    //   length 1, payload FF, bad first check, then a flushed byte equal to sync;
    //   length 2, payload 00 FF, good first check FF, bad second check;
    //   length 1, payload 80, good checks 80 80.
    logic [7:0] directed_words [22] = '{
        8'h00, 8'hFF,
        8'h7E, 8'h00, 8'h00, 8'h00,
        8'h7E, 8'h01, 8'hFF, 8'h00, 8'h7E,
        8'h7E, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'h00,
        8'h7E, 8'h01, 8'h80, 8'h80, 8'h80
    };

    // Sync byte per phase, extremes included; RANDOM_SYNC picks a fresh value.
    int sync_plan [8] = '{8'h7E, 8'h00, 8'hFF, RANDOM_SYNC, 8'hA5, RANDOM_SYNC, 8'h01, 8'h7E};

    initial begin
        int target;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i]);
        end

        // Idling mode cycles through: none, sender idle, receiver stalling, both.
        for (k = 0; k < 8; k++) begin
            write_sync((sync_plan[k] == RANDOM_SYNC) ? 8'($urandom) : 8'(sync_plan[k]));
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                send_frame();
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        // Wait out SETTLE_CYCLES more so that any stray extra word is caught.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sync_length_frame_receiver_top.f
rtl/slfr_pkg.sv
rtl/slfr_in_stage.sv
rtl/slfr_deframer.sv
rtl/slfr_out_stage.sv
rtl/sync_length_frame_receiver_top.sv
dv/sync_length_frame_receiver_top_tb.sv
